/* design/wsmvm_pkg.sv */
package wsmvm_pkg;

  // Window geometry
  localparam int WINDOW     = 7;
  localparam int MED_IDX    = (WINDOW - 1) / 2;
  localparam int CNT_W      = $clog2(WINDOW + 1);

  // Field widths
  localparam int SAMPLE_W   = 11;
  localparam int VAR_W      = 20;
  localparam int SD_W       = VAR_W / 2;

  // Accumulator widths
  localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
  localparam int SQ_W       = 2 * SAMPLE_W - 1;
  localparam int SUMSQ_W    = SQ_W + $clog2(WINDOW);
  localparam int NUM_W      = 2 * SUM_W;

  // Constant divisors
  localparam int WSQ        = WINDOW * WINDOW;
  localparam int DIV_W      = $clog2(WSQ + 1);

  // Rounded-up reciprocals; the shifts keep the quotients exact over the
  // full dividend widths
  localparam int     VAR_SH   = NUM_W + DIV_W;
  localparam longint VAR_RCP  = ((longint'(1) << VAR_SH) + longint'(WSQ) - 1) /
                                longint'(WSQ);
  localparam int     VRCP_W   = $clog2(VAR_RCP + 1);
  localparam int     MEAN_SH  = SUM_W + CNT_W;
  localparam longint MEAN_RCP = ((longint'(1) << MEAN_SH) + longint'(WINDOW) - 1) /
                                longint'(WINDOW);
  localparam int     MRCP_W   = $clog2(MEAN_RCP + 1);

  // Neighbor link of the sorting chain
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       gt;
  } link_t;

endpackage

/* design/wsmvm_ifs.sv */
interface wsmvm_sample_if;
  import wsmvm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wsmvm_result_if;
  import wsmvm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] maximum;
  logic        [VAR_W-1:0]    variance;
  logic        [SD_W-1:0]     std_dev;
  logic signed [SAMPLE_W-1:0] median;

  modport source (output valid, output mean, output minimum, output maximum,
                  output variance, output std_dev, output median, input ready);
  modport sink   (input valid, input mean, input minimum, input maximum,
                  input variance, input std_dev, input median, output ready);
endinterface

/* design/window_stats_mean_var_median_top.sv */
// Each sample beat: the accept cycle inserts it into the sorting chain and adds it
// to the sum, the next cycle adds its square; ready stays low meanwhile.
// After the last sample of a window is accepted, the result follows one reciprocal
// multiply for mean and variance and a 10-step root, and goes valid once the output
// is free. No sample of the next 7-sample window is taken before the result is loaded.
// Synchronous reset clears the sequencer, fill count, sums and output valid.
module window_stats_mean_var_median_top (
  input  logic           clk,
  input  logic           rst,
  wsmvm_sample_if.sink   samples,
  wsmvm_result_if.source results
);
  import wsmvm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_SQR  = 4'd2;
  localparam logic [3:0] S_VST  = 4'd3;
  localparam logic [3:0] S_VW   = 4'd4;
  localparam logic [3:0] S_RST  = 4'd5;
  localparam logic [3:0] S_RW   = 4'd6;
  localparam logic [3:0] S_LOAD = 4'd7;

  logic [3:0]                 state;
  logic [CNT_W-1:0]           count;
  logic                       last;
  logic                       accept;
  logic                       out_free;

  logic signed [SUM_W-1:0]    sum;
  logic [SQ_W-1:0]            sq;
  logic signed [SQ_W:0]       sq_full;
  logic [SUMSQ_W-1:0]         sumsq;
  logic signed [NUM_W-1:0]    ssq_full;
  logic [NUM_W-1:0]           ssq;
  logic [NUM_W-1:0]           wsq;
  logic [NUM_W-1:0]           num;
  logic [SUM_W-1:0]           sum_mag;

  logic signed [SAMPLE_W-1:0] r_mean;
  logic signed [SAMPLE_W-1:0] r_min;
  logic signed [SAMPLE_W-1:0] r_max;
  logic signed [SAMPLE_W-1:0] r_med;
  logic [VAR_W-1:0]           r_var;
  logic [SD_W-1:0]            r_sd;

  logic                       div_start;
  logic                       div_done;
  logic [VAR_W-1:0]           div_var;
  logic [SAMPLE_W-1:0]        div_mean;
  logic                       sqrt_start;
  logic                       sqrt_done;
  logic [SD_W-1:0]            sqrt_root;

  link_t                      links [WINDOW+1];

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;

  // Sorting chain: each cell hands its value and order flag to the right
  assign links[0].value = '0;
  assign links[0].gt    = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    wsmvm_cell u_cell (
      .clk  (clk),
      .load (accept),
      .occ  (CNT_W'(i) < count),
      .x    (samples.sample),
      .prev (links[i]),
      .nxt  (links[i+1])
    );
  end

  // Square of the incoming sample, and window-end products
  assign sq_full  = samples.sample * samples.sample;
  assign ssq_full = sum * sum;
  assign num      = (wsq < ssq) ? '0 : (wsq - ssq);
  assign sum_mag  = sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);

  // Reciprocal multiply: variance by WINDOW squared, mean by WINDOW
  assign div_start  = (state == S_VST);
  assign sqrt_start = (state == S_RST);

  wsmvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .mag      (sum_mag),
    .done     (div_done),
    .var_quo  (div_var),
    .mean_quo (div_mean)
  );

  wsmvm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (r_var),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Sequencer, fill count and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      last          <= 1'b0;
      sum           <= '0;
      sumsq         <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            sum   <= sum + SUM_W'(samples.sample);
            count <= count + 1'b1;
            last  <= (count == CNT_W'(WINDOW - 1));
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sumsq <= sumsq + SUMSQ_W'(sq);
          if (last) begin
            count <= '0;
            state <= S_SQR;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SQR: begin
          state <= S_VST;
        end
        S_VST: begin
          state <= S_VW;
        end
        S_VW: begin
          if (div_done) begin
            state <= S_RST;
          end
        end
        S_RST: begin
          state <= S_RW;
        end
        S_RW: begin
          if (sqrt_done) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            results.valid <= 1'b1;
            sum           <= '0;
            sumsq         <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sq <= sq_full[SQ_W-1:0];
    end
    if (state == S_ACC && last) begin
      r_min <= links[1].value;
      r_max <= links[WINDOW].value;
      r_med <= links[MED_IDX+1].value;
    end
    if (state == S_SQR) begin
      ssq <= $unsigned(ssq_full);
      wsq <= NUM_W'(sumsq) * NUM_W'(WINDOW);
    end
    if (state == S_VW && div_done) begin
      r_var  <= div_var;
      r_mean <= sum[SUM_W-1] ? $signed(-div_mean) : $signed(div_mean);
    end
    if (state == S_RW && sqrt_done) begin
      r_sd <= sqrt_root;
    end
    if (state == S_LOAD && out_free) begin
      results.mean     <= r_mean;
      results.minimum  <= r_min;
      results.maximum  <= r_max;
      results.variance <= r_var;
      results.std_dev  <= r_sd;
      results.median   <= r_med;
    end
  end

`ifndef SYNTHESIS
  a_order: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.minimum <= results.median) &&
                      (results.median <= results.maximum))
    else $error("median outside min/max");

  a_mean: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.minimum <= results.mean) &&
                      (results.mean <= results.maximum))
    else $error("mean outside min/max");

  a_root: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (32'(results.std_dev) * 32'(results.std_dev)) <=
                      32'(results.variance))
    else $error("std_dev squared exceeds variance");

  a_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (count < CNT_W'(WINDOW)))
    else $error("fill count past window");

  a_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_done)
    else $error("divider products late");
`endif

endmodule

/* design/wsmvm_cell.sv */
module wsmvm_cell (
  input  logic                                  clk,
  input  logic                                  load,
  input  logic                                  occ,
  input  logic signed [wsmvm_pkg::SAMPLE_W-1:0] x,
  input  wsmvm_pkg::link_t                      prev,
  output wsmvm_pkg::link_t                      nxt
);
  import wsmvm_pkg::*;

  logic signed [SAMPLE_W-1:0] value;
  logic signed [SAMPLE_W-1:0] value_next;
  logic                       gt;

  // Empty cells and cells above the new sample make room
  assign gt = !occ || (value > x);

  // Keep, take the new sample, or take the left neighbor's value
  always_comb begin
    if (!gt) begin
      value_next = value;
    end else if (!prev.gt) begin
      value_next = x;
    end else begin
      value_next = prev.value;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= value_next;
    end
  end

  assign nxt.value = value;
  assign nxt.gt    = gt;

endmodule

/* design/wsmvm_div.sv */
module wsmvm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [wsmvm_pkg::NUM_W-1:0]     num,
  input  logic [wsmvm_pkg::SUM_W-1:0]     mag,
  output logic                            done,
  output logic [wsmvm_pkg::VAR_W-1:0]     var_quo,
  output logic [wsmvm_pkg::SAMPLE_W-1:0]  mean_quo
);
  import wsmvm_pkg::*;

  localparam int VPROD_W = NUM_W + VRCP_W;
  localparam int MPROD_W = SUM_W + MRCP_W;

  logic [VPROD_W-1:0] vprod;
  logic [MPROD_W-1:0] mprod;

  // Flag the products in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Multiply by the reciprocals of WINDOW squared and WINDOW
  always_ff @(posedge clk) begin
    if (start) begin
      vprod <= VPROD_W'(num) * VPROD_W'(VAR_RCP);
      mprod <= MPROD_W'(mag) * MPROD_W'(MEAN_RCP);
    end
  end

  assign var_quo  = vprod[VAR_SH +: VAR_W];
  assign mean_quo = mprod[MEAN_SH +: SAMPLE_W];

endmodule

/* design/wsmvm_sqrt.sv */
module wsmvm_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [wsmvm_pkg::VAR_W-1:0]     radicand,
  output logic                            done,
  output logic [wsmvm_pkg::SD_W-1:0]      root
);
  import wsmvm_pkg::*;

  localparam int RCNT_W = $clog2(SD_W + 1);
  localparam int REM_W  = SD_W + 3;

  logic              busy;
  logic [RCNT_W-1:0] cnt;
  logic [VAR_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  // Bring down two radicand bits per cycle while busy
  assign rem_sh = {rem[REM_W-3:0], rad[VAR_W-1:VAR_W-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= RCNT_W'(SD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == RCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[VAR_W-3:0], 2'b00};
      rem  <= take ? (rem_sh - trial) : rem_sh;
      root <= {root[SD_W-2:0], take};
    end
  end

endmodule
